// ----- hw/rtl/bkds_pkg.sv -----
// Shared constants for the bottom-k distinct sketch.
package bkds_pkg;
    localparam int unsigned DEF_MAX_K = 1024;
    localparam int unsigned CFG_W = 11;
    localparam int unsigned CNT_OUT_W = 11;
    localparam logic [CFG_W-1:0] BOTTOM_K_RESET = 11'd1024;
    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL_A = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL_B = 64'h94d049bb133111eb;
    localparam int unsigned SH_A = 30;
    localparam int unsigned SH_B = 27;
    localparam int unsigned SH_C = 31;
endpackage

// ----- hw/rtl/bkds_front.sv -----
// Front end: accepts keys and computes the SplitMix64 hash with one shared multiplier.
module bkds_front (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] key,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        push_valid,
    input  logic        push_ready,
    output logic [63:0] push_hash
);
    import bkds_pkg::*;

    logic        busy_reg, busy_next;
    logic [2:0]  ph_reg, ph_next;
    logic [63:0] op_reg, op_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] seed;
    logic [63:0] cst;
    logic [63:0] prod;

    assign in_ready   = !busy_reg;
    assign push_valid = busy_reg && (ph_reg == 3'd6);
    assign push_hash  = acc_reg ^ (acc_reg >> SH_C);
    assign seed       = key + GOLDEN;
    assign cst        = (ph_reg < 3'd3) ? MUL_A : MUL_B;

    always_comb
    begin
        busy_next = busy_reg;
        ph_next   = ph_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        prod      = 64'd0;
        if (!busy_reg)
        begin
            if (in_valid)
            begin
                busy_next = 1'b1;
                ph_next   = 3'd0;
                op_next   = seed ^ (seed >> SH_A);
            end
        end
        else if (ph_reg == 3'd6)
        begin
            if (push_ready)
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            if (ph_reg == 3'd0 || ph_reg == 3'd3)
            begin
                prod     = op_reg[31:0] * cst[31:0];
                acc_next = prod;
            end
            else if (ph_reg == 3'd1 || ph_reg == 3'd4)
            begin
                prod     = op_reg[63:32] * cst[31:0];
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            else
            begin
                prod     = op_reg[31:0] * cst[63:32];
                acc_next = acc_reg + {prod[31:0], 32'd0};
            end
            if (ph_reg == 3'd2)
            begin
                op_next = acc_next ^ (acc_next >> SH_B);
            end
            ph_next = ph_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        acc_reg <= acc_next;
    end
endmodule

// ----- hw/rtl/bkds_fifo.sv -----
// Two-entry queue of hashes between the front end and the store.
module bkds_fifo (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_valid,
    output logic        wr_ready,
    input  logic [63:0] wr_data,
    output logic        rd_valid,
    input  logic        rd_pop,
    output logic [63:0] rd_data
);
    logic [63:0] ent_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = ent_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (do_rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            ent_reg[wp_reg] <= wr_data;
        end
    end
endmodule

// ----- hw/rtl/bkds_back.sv -----
// Back end: sorted hash store with duplicate scan, shifting insert and the result register.
module bkds_back #(
    parameter int unsigned MAX_K = bkds_pkg::DEF_MAX_K,
    parameter int unsigned AW = $clog2(MAX_K),
    parameter int unsigned CW = $clog2(MAX_K + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [CW-1:0]                 k_eff,
    input  logic                          q_valid,
    input  logic [63:0]                   q_hash,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   hash_value,
    output logic                          inserted,
    output logic [bkds_pkg::CNT_OUT_W-1:0] kept_count,
    output logic [63:0]                   largest_kept
);
    import bkds_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SHRD = 3'd2;
    localparam logic [2:0] S_SHWR = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_LAST = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [63:0]   mem [MAX_K];
    logic [63:0]   rdata;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [63:0]   wdata;

    logic [2:0]    st_reg, st_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [63:0]   big_reg, big_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          full_reg, full_next;
    logic          ins_reg, ins_next;
    logic          ov_reg, ov_next;
    logic          full_now;
    logic [AW-1:0] last_idx;

    assign full_now = (cnt_reg >= k_eff);
    assign last_idx = AW'(cnt_reg - CW'(1));
    assign out_valid = ov_reg;

    always_comb
    begin
        st_next   = st_reg;
        cnt_next  = cnt_reg;
        big_next  = big_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        full_next = full_reg;
        ins_next  = ins_reg;
        ov_next   = ov_reg && !out_ready;
        we        = 1'b0;
        waddr     = idx_reg;
        wdata     = rdata;
        raddr     = idx_reg;
        q_pop     = 1'b0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (cnt_reg == CW'(0))
                    begin
                        we       = 1'b1;
                        waddr    = AW'(0);
                        wdata    = q_hash;
                        cnt_next = CW'(1);
                        big_next = q_hash;
                        ins_next = 1'b1;
                        st_next  = S_OUT;
                    end
                    else if (!full_now || q_hash < big_reg)
                    begin
                        full_next = full_now;
                        idx_next  = last_idx;
                        pos_next  = full_now ? last_idx : AW'(cnt_reg);
                        raddr     = last_idx;
                        st_next   = S_SCAN;
                    end
                    else
                    begin
                        ins_next = 1'b0;
                        st_next  = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (rdata == q_hash)
                begin
                    ins_next = 1'b0;
                    st_next  = S_OUT;
                end
                else if (rdata < q_hash)
                begin
                    idx_next = pos_reg;
                    pos_next = idx_reg + AW'(1);
                    st_next  = S_SHRD;
                end
                else if (idx_reg == AW'(0))
                begin
                    idx_next = pos_reg;
                    pos_next = AW'(0);
                    st_next  = S_SHRD;
                end
                else
                begin
                    idx_next = idx_reg - AW'(1);
                    raddr    = idx_reg - AW'(1);
                end
            end
            S_SHRD:
            begin
                if (idx_reg == pos_reg)
                begin
                    we       = 1'b1;
                    waddr    = pos_reg;
                    wdata    = q_hash;
                    cnt_next = cnt_reg + CW'(!full_reg);
                    st_next  = S_FIN;
                end
                else
                begin
                    raddr   = idx_reg - AW'(1);
                    st_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                we       = 1'b1;
                waddr    = idx_reg;
                wdata    = rdata;
                idx_next = idx_reg - AW'(1);
                st_next  = S_SHRD;
            end
            S_FIN:
            begin
                raddr   = last_idx;
                st_next = S_LAST;
            end
            S_LAST:
            begin
                big_next = rdata;
                ins_next = 1'b1;
                st_next  = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    q_pop   = 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= S_IDLE;
            cnt_reg <= '0;
            big_reg <= 64'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            cnt_reg <= cnt_next;
            big_reg <= big_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        full_reg <= full_next;
        ins_reg  <= ins_next;
        if (q_pop)
        begin
            hash_value   <= q_hash;
            inserted     <= ins_reg;
            kept_count   <= CNT_OUT_W'(cnt_reg);
            largest_kept <= big_reg;
        end
    end
endmodule

// ----- hw/rtl/bottom_k_distinct_sketch.sv -----
// Top level of the bottom-k distinct sketch: configuration register, hash front end, queue, store.
//
//   channel   signals                                       direction
//   input     in_valid, in_ready, key                       into the block
//   output    out_valid, out_ready, hash_value, inserted,   out of the block
//             kept_count, largest_kept
//   config    cfg_we, cfg_wdata                             into the block
//
// The hash uses one 32x32 multiplier over six steps in the front end, which takes no new key
// until it has pushed the hash of the last one into the queue. The store rejects an item
// outright in its idle state when it is full and the hash is not below the largest kept; else
// it scans the entries one by one from the top down to its slot, then shifts each entry above
// the slot through a read and a write state, set by the single read and write port of the store
// memory. Reset empties the store at once through the count; no clearing pass.
// A stalled output holds its result; the front end keeps hashing into the queue until it is full.
module bottom_k_distinct_sketch #(
    parameter int unsigned MAX_K = bkds_pkg::DEF_MAX_K
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bkds_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [63:0]                   key,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [63:0]                   hash_value,
    output logic                          inserted,
    output logic [bkds_pkg::CNT_OUT_W-1:0] kept_count,
    output logic [63:0]                   largest_kept
);
    import bkds_pkg::*;

    localparam int unsigned AW = $clog2(MAX_K);
    localparam int unsigned CW = $clog2(MAX_K + 1);

    logic [CFG_W-1:0] bottom_k_reg;
    logic [CW-1:0]    k_eff;
    logic             f_valid, f_ready;
    logic [63:0]      f_hash;
    logic             q_valid, q_pop;
    logic [63:0]      q_hash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bottom_k_reg <= BOTTOM_K_RESET;
        end
        else if (cfg_we)
        begin
            bottom_k_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        if (bottom_k_reg == '0)
        begin
            k_eff = CW'(1);
        end
        else if (32'(bottom_k_reg) > 32'(MAX_K))
        begin
            k_eff = CW'(MAX_K);
        end
        else
        begin
            k_eff = CW'(bottom_k_reg);
        end
    end

    bkds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_hash  (f_hash)
    );

    bkds_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_hash),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_hash)
    );

    bkds_back #(
        .MAX_K (MAX_K),
        .AW    (AW),
        .CW    (CW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .k_eff        (k_eff),
        .q_valid      (q_valid),
        .q_hash       (q_hash),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .hash_value   (hash_value),
        .inserted     (inserted),
        .kept_count   (kept_count),
        .largest_kept (largest_kept)
    );
endmodule

// ----- verif/testbench.sv -----
// Testbench for the bottom-k distinct sketch: random and directed keys checked against a predictor.
module testbench;
    import bkds_pkg::*;

    localparam int unsigned DEPTH = DEF_MAX_K;
    localparam longint unsigned CYCLE_LIMIT = 64'd40000000;

    typedef struct packed {
        logic [63:0] hash_value;
        logic        inserted;
        logic [10:0] kept_count;
        logic [63:0] largest_kept;
    } sketch_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [63:0] key;
    logic        out_valid;
    logic        out_ready;
    logic [63:0] hash_value;
    logic        inserted;
    logic [CNT_OUT_W-1:0] kept_count;
    logic [63:0] largest_kept;

    bottom_k_distinct_sketch dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .key(key),
        .out_valid(out_valid), .out_ready(out_ready), .hash_value(hash_value),
        .inserted(inserted), .kept_count(kept_count), .largest_kept(largest_kept)
    );

    logic [63:0] pending_keys[$];
    sketch_result_t expected_results[$];
    logic [63:0] kept_sorted[$];
    logic [CFG_W-1:0] model_k;
    logic in_done;
    int  sender_idle_pct;
    int  receiver_stall_pct;
    int  hold_off_cycles;
    int  mismatch_count;
    longint unsigned cycle_count;

    function automatic logic [63:0] splitmix(input logic [63:0] v);
        logic [63:0] x;
        x = v + GOLDEN;
        x = (x ^ (x >> SH_A)) * MUL_A;
        x = (x ^ (x >> SH_B)) * MUL_B;
        return x ^ (x >> SH_C);
    endfunction

    function automatic sketch_result_t predict_sketch(input logic [63:0] k_in);
        sketch_result_t r;
        int unsigned limit;
        int unsigned n;
        int unsigned pos;
        logic [63:0] h;
        logic present;
        h = splitmix(k_in);
        limit = (model_k == 0) ? 1 : ((model_k > DEPTH) ? DEPTH : model_k);
        present = 1'b0;
        foreach (kept_sorted[i])
            if (kept_sorted[i] == h)
                present = 1'b1;
        r.inserted = 1'b0;
        n = kept_sorted.size();
        if (!present) begin
            if (n < limit) begin
                r.inserted = 1'b1;
            end
            else if (n > 0 && h < kept_sorted[n-1]) begin
                kept_sorted.pop_back();
                r.inserted = 1'b1;
            end
            if (r.inserted) begin
                pos = 0;
                while (pos < kept_sorted.size() && kept_sorted[pos] < h)
                    pos++;
                kept_sorted.insert(pos, h);
            end
        end
        n = kept_sorted.size();
        r.hash_value = h;
        r.kept_count = n[10:0];
        r.largest_kept = (n > 0) ? kept_sorted[n-1] : 64'd0;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        in_done = rst_n && in_valid && in_ready;
        if (in_done)
            expected_results.push_back(predict_sketch(key));
    end

    always @(negedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_done) begin
            if (pending_keys.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                in_valid <= 1'b1;
                key <= pending_keys.pop_front();
            end
            else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sketch_result_t exp_r;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result, hash %h", hash_value);
            end
            else begin
                exp_r = expected_results.pop_front();
                if (hash_value !== exp_r.hash_value || inserted !== exp_r.inserted ||
                    kept_count !== exp_r.kept_count || largest_kept !== exp_r.largest_kept)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h %b %0d %h, got %h %b %0d %h",
                            exp_r.hash_value, exp_r.inserted, exp_r.kept_count,
                            exp_r.largest_kept, hash_value, inserted, kept_count,
                            largest_kept);
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_keys.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_bottom_k(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_k = value;
    endtask

    task automatic queue_random(input int count, input int unsigned span);
        logic [63:0] v;
        repeat (count) begin
            case ($urandom_range(3))
                0: v = {$urandom, $urandom};
                1: v = 64'($urandom_range(span));
                2: v = ~64'($urandom_range(span));
                default: v = 64'd1 << $urandom_range(63);
            endcase
            pending_keys.push_back(v);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        in_done = 1'b0;
        key = '0;
        out_ready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 0;
        mismatch_count = 0;
        cycle_count = 0;
        model_k = BOTTOM_K_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        pending_keys.push_back(64'd0);
        pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        pending_keys.push_back(64'd0);
        pending_keys.push_back(64'h8000_0000_0000_0000);
        pending_keys.push_back(64'h5555_5555_5555_5555);
        pending_keys.push_back(64'hAAAA_AAAA_AAAA_AAAA);
        pending_keys.push_back(64'd1);
        pending_keys.push_back(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();

        write_bottom_k(11'd0);
        for (int i = 0; i < 6; i++)
            pending_keys.push_back(64'(i));
        wait_drained();

        write_bottom_k(11'd3);
        for (int i = 10; i < 18; i++)
            pending_keys.push_back(64'(i));
        pending_keys.push_back(64'd10);
        wait_drained();

        write_bottom_k(11'h7FF);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_random(200, 300);
        hold_off_cycles = 3000;
        wait_drained();

        write_bottom_k(11'd2);
        sender_idle_pct = 50;
        queue_random(250, 100);
        wait_drained();

        write_bottom_k(11'd16);
        sender_idle_pct = 0;
        receiver_stall_pct = 50;
        queue_random(300, 60);
        wait_drained();

        write_bottom_k(11'd1);
        sender_idle_pct = 15;
        receiver_stall_pct = 15;
        queue_random(200, 40);
        wait_drained();

        write_bottom_k(11'd1024);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        queue_random(280, 1000);
        wait_drained();

        write_bottom_k(11'd1025);
        sender_idle_pct = 50;
        receiver_stall_pct = 50;
        queue_random(200, 500);
        wait_drained();

        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
